// File: src/fwrbv_pkg.sv
// ----------------------------------------------------------------------------
// fwrbv_pkg
// shared widths, operation codes and cell control type for the value queue
// ----------------------------------------------------------------------------
package fwrbv_pkg;

   localparam int KIND_W        = 2;
   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEF     = 16;
   localparam int VALUE_W_DEF   = 32;

   localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REM = 2'd2;

   // command broadcast to every cell for one accepted request
   typedef struct packed {
      logic enq;
      logic deq;
      logic rem;
   } cell_cmd_type;

endpackage

// File: src/fwrbv_req_if.sv
// ----------------------------------------------------------------------------
// fwrbv_req_if
// request channel: operation code and value, valid/ready handshake
// ----------------------------------------------------------------------------
interface fwrbv_req_if;
   logic                             valid;
   logic                             ready;
   logic [fwrbv_pkg::KIND_W-1:0]     kind;
   logic [fwrbv_pkg::DATA_W-1:0]     item_value;

   modport source (output valid, kind, item_value, input ready);
   modport sink   (input valid, kind, item_value, output ready);
endinterface

// File: src/fwrbv_rsp_if.sv
// ----------------------------------------------------------------------------
// fwrbv_rsp_if
// response channel: dequeued value, success flag and entry count
// ----------------------------------------------------------------------------
interface fwrbv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fwrbv_pkg::DATA_W-1:0]      out_value;
   logic                              success;
   logic [fwrbv_pkg::COUNT_W-1:0]     entry_count;

   modport source (output valid, out_value, success, entry_count, input ready);
   modport sink   (input valid, out_value, success, entry_count, output ready);
endinterface

// File: src/fifo_with_remove_by_value.sv
// ----------------------------------------------------------------------------
// fifo_with_remove_by_value
// ordered queue with enqueue, dequeue and remove of the first equal entry,
// built as a row of compare-and-shift cells with slot 0 at the head
// ----------------------------------------------------------------------------
//  channel   direction  payload                              handshake
//  req       in         kind, item_value                     valid / ready
//  rsp       out        out_value, success, entry_count      valid / ready
//
//  one request per cycle while req.ready is high: every cell compares and shifts in the same cycle,
//  and the response is held in an output register
//  the first-match search ripples a found flag through the row of cells,
//  which sets the cycle length for large DEPTH
//  reset empties the queue and drops any pending response
//  req.ready stays high while the response register is empty or being taken
// ----------------------------------------------------------------------------
module fifo_with_remove_by_value #(
   parameter int DEPTH       = fwrbv_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = fwrbv_pkg::VALUE_W_DEF
) (
   input  logic          clock,
   input  logic          reset,
   fwrbv_req_if.sink     req_chan,
   fwrbv_rsp_if.source   rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                    accept;
   fwrbv_pkg::cell_cmd_type cmd;
   logic [VALUE_WIDTH-1:0]  key;

   // valid_chain[k] is the valid flag of cell k-1
   logic [DEPTH+1:0]        valid_chain;
   logic [DEPTH:0]          found_chain;
   logic [VALUE_WIDTH-1:0]  value_chain [DEPTH+1];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    full, empty;
   logic                    enq_ok, deq_ok, rem_ok;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fwrbv_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                          rsp_success_ff, rsp_success_in;
   logic [fwrbv_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign key            = VALUE_WIDTH'(req_chan.item_value);

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.enq = accept && (req_chan.kind == fwrbv_pkg::KIND_ENQ) && !full;
      cmd.deq = accept && (req_chan.kind == fwrbv_pkg::KIND_DEQ) && !empty;
      cmd.rem = accept && (req_chan.kind == fwrbv_pkg::KIND_REM);
   end

   // cell 0 sees a filled slot below it, the top cell an empty one above it
   assign valid_chain[0]       = 1'b1;
   assign found_chain[0]       = 1'b0;
   assign valid_chain[DEPTH+1] = 1'b0;
   assign value_chain[DEPTH]   = '0;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         fwrbv_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .key        (key),
            .prev_valid (valid_chain[g]),
            .next_valid (valid_chain[g+2]),
            .next_value (value_chain[g+1]),
            .found_in   (found_chain[g]),
            .valid      (valid_chain[g+1]),
            .value      (value_chain[g]),
            .found_out  (found_chain[g+1])
         );
      end
   endgenerate

   assign enq_ok = cmd.enq;
   assign deq_ok = cmd.deq;
   assign rem_ok = cmd.rem & found_chain[DEPTH];

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok || rem_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_success_in = rsp_success_ff;
      rsp_count_in   = rsp_count_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = deq_ok ? fwrbv_pkg::DATA_W'(value_chain[0]) : '0;
         rsp_success_in = enq_ok | deq_ok | rem_ok;
         rsp_count_in   = fwrbv_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff   <= rsp_value_in;
      rsp_success_ff <= rsp_success_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_value   = rsp_value_ff;
   assign rsp_chan.success     = rsp_success_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// File: src/fwrbv_cell.sv
// ----------------------------------------------------------------------------
// fwrbv_cell
// one queue slot: holds a value, compares it with the key, shifts from its
// upper neighbour when an entry at or below it is taken out
// ----------------------------------------------------------------------------
module fwrbv_cell #(
   parameter int VALUE_WIDTH = fwrbv_pkg::VALUE_W_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fwrbv_pkg::cell_cmd_type      cmd,
   input  logic [VALUE_WIDTH-1:0]       key,
   input  logic                         prev_valid,
   input  logic                         next_valid,
   input  logic [VALUE_WIDTH-1:0]       next_value,
   input  logic                         found_in,
   output logic                         valid,
   output logic [VALUE_WIDTH-1:0]       value,
   output logic                         found_out
);

   logic                    valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    hit;
   logic                    shift;
   logic                    load;

   assign hit       = valid_ff && (value_ff == key);
   assign found_out = found_in | hit;
   assign shift     = cmd.deq | (cmd.rem & found_out);
   // first empty slot above a filled one is the tail
   assign load      = cmd.enq & ~valid_ff & prev_valid;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (shift) begin
         valid_in = next_valid;
         value_in = next_value;
      end else if (load) begin
         valid_in = 1'b1;
         value_in = key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

// File: test/tb_fifo_with_remove_by_value.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_with_remove_by_value
// drives enqueue, dequeue and remove-by-value requests into the value queue,
// first from a short table of corner cases, then in random bursts that fill,
// drain and search the queue under several idling patterns on both channels;
// every response is checked per field against a table row or a model in the bench
// ----------------------------------------------------------------------------
module tb_fifo_with_remove_by_value;

   localparam int QUEUE_DEPTH   = fwrbv_pkg::DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;

   // kind code that the block ignores
   localparam logic [fwrbv_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      logic [fwrbv_pkg::DATA_W-1:0]  out_value;
      logic                          success;
      logic [fwrbv_pkg::COUNT_W-1:0] entry_count;
   } queue_reply_type;

   typedef struct packed {
      logic [fwrbv_pkg::KIND_W-1:0] op;
      logic [fwrbv_pkg::DATA_W-1:0] value;
      logic                         typed;
      queue_reply_type              want;
   } stim_row_type;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SEARCH, MIX_ANY} traffic_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fwrbv_req_if req_chan ();
   fwrbv_rsp_if rsp_chan ();

   fifo_with_remove_by_value uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   logic [fwrbv_pkg::DATA_W-1:0] model_entries[$];
   queue_reply_type              pending_replies[$];
   stim_row_type                 directed_rows[$];

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   traffic_mix_type mix       = MIX_FILL;
   int              mix_left  = 0;

   // queue model: slot 0 is the head, a remove closes the gap
   function automatic queue_reply_type queue_model_step(
      input logic [fwrbv_pkg::KIND_W-1:0] op,
      input logic [fwrbv_pkg::DATA_W-1:0] value);
      queue_reply_type reply;
      int              hit;
      reply = '0;
      hit   = -1;
      case (op)
         fwrbv_pkg::KIND_ENQ: begin
            if (model_entries.size() < QUEUE_DEPTH) begin
               model_entries.push_back(value);
               reply.success = 1'b1;
            end
         end
         fwrbv_pkg::KIND_DEQ: begin
            if (model_entries.size() > 0) begin
               reply.out_value = model_entries.pop_front();
               reply.success   = 1'b1;
            end
         end
         fwrbv_pkg::KIND_REM: begin
            for (int i = 0; i < model_entries.size(); i++)
               if (hit < 0 && model_entries[i] == value) hit = i;
            if (hit >= 0) begin
               model_entries.delete(hit);
               reply.success = 1'b1;
            end
         end
         default: begin
         end
      endcase
      reply.entry_count = fwrbv_pkg::COUNT_W'(model_entries.size());
      return reply;
   endfunction

   task automatic add_row(input logic [fwrbv_pkg::KIND_W-1:0] op,
                          input logic [fwrbv_pkg::DATA_W-1:0] value,
                          input logic typed, input queue_reply_type want);
      stim_row_type row;
      row.op    = op;
      row.value = value;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   function automatic logic [fwrbv_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3, 4: begin
            // small pool so that duplicates turn up often
            return fwrbv_pkg::DATA_W'($urandom_range(7));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic send_request(input logic [fwrbv_pkg::KIND_W-1:0] op,
                               input logic [fwrbv_pkg::DATA_W-1:0] value,
                               input logic typed, input queue_reply_type want);
      queue_reply_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= op;
      req_chan.item_value <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = queue_model_step(op, value);
      pending_replies.push_back(typed ? want : predicted);
   endtask

   task automatic send_random(output logic [fwrbv_pkg::KIND_W-1:0] op);
      logic [fwrbv_pkg::DATA_W-1:0] value;
      int                           roll;
      if (mix_left == 0) begin
         mix      = traffic_mix_type'($urandom_range(3));
         mix_left = $urandom_range(4, 24);
      end
      mix_left--;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            op = roll < 80 ? fwrbv_pkg::KIND_ENQ :
                 roll < 90 ? fwrbv_pkg::KIND_DEQ :
                 roll < 98 ? fwrbv_pkg::KIND_REM : KIND_NONE;
         end
         MIX_DRAIN: begin
            op = roll < 10 ? fwrbv_pkg::KIND_ENQ :
                 roll < 80 ? fwrbv_pkg::KIND_DEQ :
                 roll < 98 ? fwrbv_pkg::KIND_REM : KIND_NONE;
         end
         MIX_SEARCH: begin
            op = roll < 25 ? fwrbv_pkg::KIND_ENQ :
                 roll < 40 ? fwrbv_pkg::KIND_DEQ :
                 roll < 97 ? fwrbv_pkg::KIND_REM : KIND_NONE;
         end
         default: begin
            op = roll < 30 ? fwrbv_pkg::KIND_ENQ :
                 roll < 60 ? fwrbv_pkg::KIND_DEQ :
                 roll < 90 ? fwrbv_pkg::KIND_REM : KIND_NONE;
         end
      endcase
      // removes mostly aim at a value that is held somewhere in the queue
      if (op == fwrbv_pkg::KIND_REM && model_entries.size() > 0 && $urandom_range(3) != 0)
         value = model_entries[$urandom_range(model_entries.size() - 1)];
      else
         value = pick_value();
      send_request(op, value, 1'b0, '0);
   endtask

   task automatic report_mismatch(input string what, input queue_reply_type want,
                                  input queue_reply_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected %h/%0d/%0d, got %h/%0d/%0d (value/success/count)",
                  $realtime, what, want.out_value, want.success, want.entry_count,
                  got.out_value, got.success, got.entry_count);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      queue_reply_type got;
      queue_reply_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end else if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_value   = rsp_chan.out_value;
            got.success     = rsp_chan.success;
            got.entry_count = rsp_chan.entry_count;
            if (pending_replies.size() == 0) begin
               report_mismatch("response with no request pending", '0, got);
            end else begin
               want = pending_replies.pop_front();
               if (got.out_value !== want.out_value || got.success !== want.success ||
                   got.entry_count !== want.entry_count)
                  report_mismatch("response mismatch", want, got);
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int                           send_idle_by_phase[4];
      int                           rsp_stall_by_phase[4];
      int                           counted;
      logic [fwrbv_pkg::KIND_W-1:0] op;

      send_idle_by_phase = '{0, 79, 0, 18};
      rsp_stall_by_phase = '{0, 0, 79, 18};

      req_chan.valid      <= 1'b0;
      req_chan.kind       <= fwrbv_pkg::KIND_ENQ;
      req_chan.item_value <= '0;

      // corner cases on an empty queue, then fill to the brim, overfill and remove
      add_row(fwrbv_pkg::KIND_DEQ, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 5'd0});
      add_row(fwrbv_pkg::KIND_REM, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 5'd0});
      add_row(KIND_NONE,           32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 5'd0});
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 5'd1});
      // removing the only entry must leave the queue truly empty
      add_row(fwrbv_pkg::KIND_REM, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 5'd0});
      add_row(fwrbv_pkg::KIND_DEQ, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 5'd0});
      add_row(fwrbv_pkg::KIND_ENQ, 32'hFFFF_FFFF, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0000_0000, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hAAAA_AAAA, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h5555_5555, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hAAAA_AAAA, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h8000_0000, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0000_0001, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h7FFF_FFFF, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h1234_5678, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hDEAD_BEEF, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0F0F_0F0F, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hF0F0_F0F0, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0000_FFFF, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hFFFF_0000, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'h0000_0002, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hFFFF_FFFE, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_ENQ, 32'hCAFE_F00D, 1'b1, '{32'h0, 1'b0, 5'd16});
      add_row(fwrbv_pkg::KIND_REM, 32'hAAAA_AAAA, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_REM, 32'h1357_9BDF, 1'b0, '0);
      add_row(fwrbv_pkg::KIND_DEQ, 32'h0000_0000, 1'b0, '0);
      add_row(KIND_NONE,           32'h5555_5555, 1'b0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].want);

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         rsp_stall_pct = rsp_stall_by_phase[phase];
         counted = 0;
         while (counted < RANDOM_ITEMS / 4) begin
            send_random(op);
            if (op != KIND_NONE) counted++;
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: fifo_with_remove_by_value.f
src/fwrbv_pkg.sv
src/fwrbv_req_if.sv
src/fwrbv_rsp_if.sv
src/fwrbv_cell.sv
src/fifo_with_remove_by_value.sv
test/tb_fifo_with_remove_by_value.sv
